>>> rtl/mtm_pkg.sv
// Package for the MUS to MIDI event converter.
// Holds result codes, MIDI constants, the result word type and the mapping tables.
// Depends on nothing.
package mtm_pkg;

    localparam int CHANNEL_COUNT      = 16;
    localparam int CHANNEL_BITS       = $clog2(CHANNEL_COUNT);
    localparam int DELAY_BITS_DEFAULT = 28;
    localparam int DELAY_OUT_BITS     = 28;

    localparam logic [1:0] RK_EVENT = 2'd0;
    localparam logic [1:0] RK_END   = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    localparam logic [2:0] EV_RELEASE    = 3'd0;
    localparam logic [2:0] EV_NOTE_ON    = 3'd1;
    localparam logic [2:0] EV_BEND       = 3'd2;
    localparam logic [2:0] EV_SYSTEM     = 3'd3;
    localparam logic [2:0] EV_CONTROLLER = 3'd4;
    localparam logic [2:0] EV_FIRST_END  = 3'd5;

    localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
    localparam logic [3:0] ST_NOTE_ON    = 4'h9;
    localparam logic [3:0] ST_CONTROL    = 4'hB;
    localparam logic [3:0] ST_PROGRAM    = 4'hC;
    localparam logic [3:0] ST_PITCH_BEND = 4'hE;

    localparam logic [3:0] CH_PERCUSSION = 4'd9;
    localparam logic [3:0] CH_LAST       = 4'd15;

    localparam logic [7:0] VOLUME_RESET  = 8'd127;
    localparam logic [7:0] PROGRAM_VALUE = 8'd64;
    localparam logic [7:0] CTRL_INDEX_MAX = 8'd9;

    typedef struct packed {
        logic [1:0]                kind;
        logic [DELAY_OUT_BITS-1:0] delay;
        logic [7:0]                status;
        logic [7:0]                data1;
        logic [7:0]                data2;
    } mtm_result_t;

    function automatic logic [7:0] ctrl_map(input logic [3:0] index);
        logic [7:0] code;
        case (index)
            4'd0:    code = 8'd0;
            4'd1:    code = 8'd0;
            4'd2:    code = 8'd1;
            4'd3:    code = 8'd7;
            4'd4:    code = 8'd10;
            4'd5:    code = 8'd11;
            4'd6:    code = 8'd91;
            4'd7:    code = 8'd93;
            4'd8:    code = 8'd64;
            4'd9:    code = 8'd67;
            default: code = 8'd0;
        endcase
        return code;
    endfunction

    // Bit 8 of the result flags a known system event.
    function automatic logic [8:0] system_map(input logic [7:0] value);
        logic [8:0] code;
        case (value)
            8'd10:   code = {1'b1, 8'd120};
            8'd11:   code = {1'b1, 8'd123};
            8'd12:   code = {1'b1, 8'd126};
            8'd13:   code = {1'b1, 8'd127};
            8'd14:   code = {1'b1, 8'd121};
            default: code = 9'd0;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/mtm_parser.sv
// Score byte parser for the MUS to MIDI event converter.
// Holds the parse state, pending delay and channel volume table; emits one result word.
// Depends on mtm_pkg.
module mtm_parser #(
    parameter int DELAY_BITS = mtm_pkg::DELAY_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          score_byte,
    output logic                res_valid,
    output mtm_pkg::mtm_result_t res
);
    import mtm_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;
    localparam logic [1:0] PH_DELAY  = 2'd3;

    logic [1:0]              phase_reg, phase_next;
    logic [2:0]              kind_reg, kind_next;
    logic [CHANNEL_BITS-1:0] channel_reg, channel_next;
    logic                    follows_reg, follows_next;
    logic [7:0]              operand_reg, operand_next;
    logic [DELAY_BITS-1:0]   pending_reg, pending_next;
    logic                    stopped_reg, stopped_next;
    logic [7:0]              volume_reg [CHANNEL_COUNT];

    logic                    vol_write;
    logic [7:0]              vol_cur;
    logic                    emit;
    logic [1:0]              emit_kind;
    logic [7:0]              emit_status;
    logic [7:0]              emit_d1;
    logic [7:0]              emit_d2;
    logic [3:0]              raw_channel;
    logic [8:0]              sys_code;
    logic [DELAY_BITS+6:0]   delay_acc;
    logic [DELAY_BITS+DELAY_OUT_BITS-1:0] delay_wide;

    assign vol_cur    = volume_reg[channel_reg];
    assign raw_channel = score_byte[3:0];
    assign sys_code   = system_map(score_byte);
    assign delay_acc  = {pending_reg, score_byte[6:0]};
    assign delay_wide = {{DELAY_OUT_BITS{1'b0}}, pending_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        channel_next = channel_reg;
        follows_next = follows_reg;
        operand_next = operand_reg;
        pending_next = pending_reg;
        stopped_next = stopped_reg;
        vol_write    = 1'b0;
        emit         = 1'b0;
        emit_kind    = RK_EVENT;
        emit_status  = 8'd0;
        emit_d1      = 8'd0;
        emit_d2      = 8'd0;
        if (accept && !stopped_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    kind_next    = score_byte[6:4];
                    follows_next = score_byte[7];
                    if (raw_channel == CH_PERCUSSION)
                        channel_next = CH_LAST;
                    else if (raw_channel == CH_LAST)
                        channel_next = CH_PERCUSSION;
                    else
                        channel_next = raw_channel;
                    if (score_byte[6:4] >= EV_FIRST_END)
                    begin
                        emit      = 1'b1;
                        emit_kind = RK_END;
                    end
                    else
                        phase_next = PH_FIRST;
                end
                PH_FIRST:
                begin
                    operand_next = score_byte;
                    case (kind_reg)
                        EV_RELEASE:
                        begin
                            emit        = 1'b1;
                            emit_status = {ST_NOTE_OFF, channel_reg};
                            emit_d1     = score_byte;
                            emit_d2     = vol_cur;
                        end
                        EV_NOTE_ON:
                        begin
                            if (score_byte[7])
                                phase_next = PH_SECOND;
                            else
                            begin
                                emit        = 1'b1;
                                emit_status = {ST_NOTE_ON, channel_reg};
                                emit_d1     = {1'b0, score_byte[6:0]};
                                emit_d2     = vol_cur;
                            end
                        end
                        EV_BEND:
                        begin
                            emit        = 1'b1;
                            emit_status = {ST_PITCH_BEND, channel_reg};
                            emit_d1     = {1'b0, score_byte[0], 6'd0};
                            emit_d2     = {1'b0, score_byte[7:1]};
                        end
                        EV_SYSTEM:
                        begin
                            emit = 1'b1;
                            if (sys_code[8])
                            begin
                                emit_status = {ST_CONTROL, channel_reg};
                                emit_d1     = sys_code[7:0];
                            end
                            else
                                emit_kind = RK_ERROR;
                        end
                        default:
                        begin
                            if (score_byte > CTRL_INDEX_MAX)
                            begin
                                emit      = 1'b1;
                                emit_kind = RK_ERROR;
                            end
                            else
                                phase_next = PH_SECOND;
                        end
                    endcase
                end
                PH_SECOND:
                begin
                    emit = 1'b1;
                    if (kind_reg == EV_NOTE_ON)
                    begin
                        vol_write   = 1'b1;
                        emit_status = {ST_NOTE_ON, channel_reg};
                        emit_d1     = {1'b0, operand_reg[6:0]};
                        emit_d2     = score_byte;
                    end
                    else if (operand_reg == 8'd0)
                    begin
                        emit_status = {ST_PROGRAM, channel_reg};
                        emit_d1     = score_byte;
                        emit_d2     = PROGRAM_VALUE;
                    end
                    else
                    begin
                        emit_status = {ST_CONTROL, channel_reg};
                        emit_d1     = ctrl_map(operand_reg[3:0]);
                        emit_d2     = score_byte;
                    end
                end
                default:
                begin
                    if (delay_acc[DELAY_BITS+6:DELAY_BITS] != 7'd0)
                        pending_next = {DELAY_BITS{1'b1}};
                    else
                        pending_next = delay_acc[DELAY_BITS-1:0];
                    if (!score_byte[7])
                        phase_next = PH_HEADER;
                end
            endcase
            if (emit)
            begin
                pending_next = '0;
                if (emit_kind != RK_EVENT)
                    stopped_next = 1'b1;
                else
                    phase_next = follows_reg ? PH_DELAY : PH_HEADER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            kind_reg    <= 3'd0;
            channel_reg <= '0;
            follows_reg <= 1'b0;
            operand_reg <= 8'd0;
            pending_reg <= '0;
            stopped_reg <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
                volume_reg[i] <= VOLUME_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            channel_reg <= channel_next;
            follows_reg <= follows_next;
            operand_reg <= operand_next;
            pending_reg <= pending_next;
            stopped_reg <= stopped_next;
            if (vol_write)
                volume_reg[channel_reg] <= score_byte;
        end
    end

    assign res_valid  = emit;
    assign res.kind   = emit_kind;
    assign res.delay  = delay_wide[DELAY_OUT_BITS-1:0];
    assign res.status = emit_status;
    assign res.data1  = emit_d1;
    assign res.data2  = emit_d2;

    assert property (@(posedge clk) disable iff (!rst_n) stopped_reg |-> !res_valid)
        else $error("Result produced after score end or error.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind != RK_EVENT) |=> stopped_reg)
        else $error("Parser did not stop after a terminal result.");

endmodule

>>> rtl/mtm_out_queue.sv
// Two-entry output buffer for the MUS to MIDI event converter.
// An output register plus a skid register decouple the result receiver from the parser.
// Depends on mtm_pkg.
module mtm_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mtm_pkg::mtm_result_t push_word,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mtm_pkg::mtm_result_t out_word
);
    import mtm_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    mtm_result_t out_reg, out_next;
    mtm_result_t skid_reg, skid_next;
    logic        pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = push_word;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_word;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held while the output register is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("Skid entry not moved to the output register on a pop.");

endmodule

>>> rtl/mus_to_midi_event_converter_top.sv
// Top level of the MUS to MIDI event converter.
// Instantiates the score parser and the output buffer; depends on mtm_pkg.
//
// Usage: score body bytes enter one word at a time on the score channel
// (score_valid, score_stall, score_byte), starting at the first event header.
// Each complete MUS event leaves as one word on the event channel
// (event_valid, event_stall and the result fields): a MIDI short message with
// the delay that preceded it, or a score end or format error word.
// A byte is parsed in the cycle it is accepted and its result word is
// registered in the output register, or in the skid register on a stall.
// One byte is accepted every cycle unless score_stall is high; the rate is set
// by the single parse step on the registered parse state.
// When the receiver stalls, the output register holds its word and a skid
// register takes one more result; score_stall rises only when both are full.
// Reset clears the parse state, the pending delay and both buffer entries,
// and sets all sixteen channel volumes to 127. After a score end or error
// word, bytes are still accepted but ignored until the next reset.
module mus_to_midi_event_converter_top #(
    parameter int DELAY_BITS = mtm_pkg::DELAY_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               score_valid,
    output logic                               score_stall,
    input  logic [7:0]                         score_byte,
    output logic                               event_valid,
    input  logic                               event_stall,
    output logic [1:0]                         result_kind,
    output logic [mtm_pkg::DELAY_OUT_BITS-1:0] delay_ticks,
    output logic [7:0]                         status_byte,
    output logic [7:0]                         data_first,
    output logic [7:0]                         data_second
);
    import mtm_pkg::*;

    logic        accept;
    logic        res_valid;
    mtm_result_t res;
    mtm_result_t out_word;
    logic        full;

    assign accept      = score_valid && !full;
    assign score_stall = full;

    mtm_parser #(
        .DELAY_BITS (DELAY_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .score_byte (score_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    mtm_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_word (res),
        .full      (full),
        .out_valid (event_valid),
        .out_stall (event_stall),
        .out_word  (out_word)
    );

    assign result_kind = out_word.kind;
    assign delay_ticks = out_word.delay;
    assign status_byte = out_word.status;
    assign data_first  = out_word.data1;
    assign data_second = out_word.data2;

endmodule
